FILE: rtl/glpc_pkg.sv
package glpc_pkg;

  localparam int CoordW     = 20;
  localparam int SumW       = 40;
  localparam int LimW       = 19;
  localparam int StatusW    = 3;
  localparam int FieldUnits = 1000;
  localparam logic [LimW-1:0] LimReset = 19'd262144;

  typedef enum logic [StatusW-1:0] {
    ST_JOIN     = 3'd0,
    ST_NEW      = 3'd1,
    ST_OUTSIDE  = 3'd2,
    ST_NO_FREE  = 3'd3,
    ST_CELL_FULL = 3'd4,
    ST_SATURATED = 3'd5
  } status_e;

  // result of one centroid distance test
  typedef struct packed {
    logic done;
    logic hit;
  } near_res_t;

endpackage

FILE: rtl/glpc_near.sv
module glpc_near #(
  parameter int COUNT_BITS = 20
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [glpc_pkg::CoordW-1:0]  x_i,
  input  logic signed [glpc_pkg::CoordW-1:0]  y_i,
  input  logic [COUNT_BITS-1:0]               n_i,
  input  logic signed [glpc_pkg::SumW-1:0]    sx_i,
  input  logic signed [glpc_pkg::SumW-1:0]    sy_i,
  input  logic [glpc_pkg::LimW-1:0]           lim_i,
  output glpc_pkg::near_res_t                 res_o
);

  localparam int PW  = glpc_pkg::CoordW + 1 + COUNT_BITS;
  localparam int DW  = ((PW > glpc_pkg::SumW) ? PW : glpc_pkg::SumW) + 1;
  localparam int BW  = COUNT_BITS + 10;
  localparam int QW  = 2 * BW;
  localparam int NW  = glpc_pkg::LimW + COUNT_BITS;
  localparam int LW  = glpc_pkg::LimW + 2 * COUNT_BITS;
  localparam int CW  = QW + 1;

  logic signed [PW-1:0] px_q, py_q;
  logic [NW-1:0]        ln_q;
  logic [DW-1:0]        ax_q, ay_q;
  logic [LW-1:0]        lnn_q;
  logic                 over_q;
  logic [QW-1:0]        axx_q, ayy_q;
  logic                 hit_q;
  logic [3:0]           v_q;

  logic signed [DW-1:0] diff_x, diff_y;
  logic [BW-1:0]        bound;

  always_comb begin
    diff_x = DW'(px_q) - DW'(sx_i);
    diff_y = DW'(py_q) - DW'(sy_i);
    bound  = {n_i, 10'b0};
  end

  // stage 1: products, stage 2: distances, stage 3: squares, stage 4: compare
  always_ff @(posedge clk_i) begin
    px_q   <= PW'(x_i) * PW'($signed({1'b0, n_i}));
    py_q   <= PW'(y_i) * PW'($signed({1'b0, n_i}));
    ln_q   <= NW'(lim_i) * NW'(n_i);
    ax_q   <= diff_x[DW-1] ? DW'(-diff_x) : DW'(diff_x);
    ay_q   <= diff_y[DW-1] ? DW'(-diff_y) : DW'(diff_y);
    lnn_q  <= LW'(ln_q) * LW'(n_i);
    over_q <= (ax_q > DW'(bound)) || (ay_q > DW'(bound));
    axx_q  <= QW'(ax_q[BW-1:0]) * QW'(ax_q[BW-1:0]);
    ayy_q  <= QW'(ay_q[BW-1:0]) * QW'(ay_q[BW-1:0]);
    hit_q  <= !over_q && ((CW'(axx_q) + CW'(ayy_q)) <= CW'(lnn_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[2:0], start_i};
    end
  end

  assign res_o.done = v_q[3];
  assign res_o.hit  = hit_q;

endmodule

FILE: rtl/grid_leader_point_clustering_top.sv
// Grid leader clustering. Assert start for one cycle while busy is low to
// request one point; exactly one result follows, shown for a single cycle on
// done_o, and the receiver cannot stall it. A point that seeds a new cluster or
// is dropped is answered after the scan, which tests every stored cluster in
// the neighbourhood (at most 36): the sequencer walks nine cells, reading one
// cell row and then one cluster row at a time from memories with one read
// port each, and each candidate goes through a four-stage distance test. A
// join ends at the matching cluster, and a point outside the field is
// answered in the next cycle. After reset the block clears the cell memory,
// one row a cycle, all GRID_SIDE*GRID_SIDE rows (about one million by
// default) with busy high; configuration writes are taken at any time.
module grid_leader_point_clustering_top #(
  parameter int MAX_CLUSTERS = 16384,
  parameter int GRID_SIDE    = 1024,
  parameter int CELL_SLOTS   = 4,
  parameter int COUNT_BITS   = 20,
  parameter int FRAC_BITS    = 8,
  localparam int IdW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [glpc_pkg::CoordW-1:0] point_x_i,
  input  logic signed [glpc_pkg::CoordW-1:0] point_y_i,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [glpc_pkg::LimW-1:0]          cfg_data_i,
  output logic                               done_o,
  output logic [IdW-1:0]                     cluster_id_o,
  output logic [glpc_pkg::StatusW-1:0]       status_o,
  output logic [COUNT_BITS-1:0]              member_count_o,
  output logic signed [glpc_pkg::SumW-1:0]   sum_x_o,
  output logic signed [glpc_pkg::SumW-1:0]   sum_y_o
);

  localparam int UW    = IdW + 1;
  localparam int GW    = $clog2(GRID_SIDE);
  localparam int Cells = GRID_SIDE * GRID_SIDE;
  localparam int CAW   = $clog2(Cells);
  localparam int KW    = (CELL_SLOTS > 1) ? $clog2(CELL_SLOTS) : 1;
  localparam int FW    = $clog2(CELL_SLOTS + 1);
  localparam int SlW   = CELL_SLOTS * IdW;
  localparam int RW    = FW + SlW;
  localparam int SumW  = glpc_pkg::SumW;
  localparam int CRW   = COUNT_BITS + 2 * SumW;
  localparam int Shift = FRAC_BITS + 1;
  localparam int SW    = (GW + Shift + 1 > 21) ? GW + Shift + 1 : 21;
  localparam int LW    = (FRAC_BITS + 12 > 21) ? FRAC_BITS + 12 : 21;
  localparam logic signed [LW-1:0] LimP = LW'(glpc_pkg::FieldUnits << FRAC_BITS);
  localparam logic signed [SW-1:0] Bias = SW'((GRID_SIDE / 2) << Shift);
  localparam logic [UW-1:0]        MaxU = UW'(MAX_CLUSTERS);
  localparam logic [FW-1:0]        SlotsF = FW'(CELL_SLOTS);
  localparam logic [CAW-1:0]       LastCell = CAW'(Cells - 1);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_CELL, S_ROW, S_SLOT, S_CLU, S_TEST, S_DECIDE
  } state_e;

  state_e state_q, state_d;
  logic signed [glpc_pkg::CoordW-1:0] x_q, x_d, y_q, y_d;
  logic [GW-1:0]   cx_q, cx_d, cy_q, cy_d;
  logic [1:0]      dxi_q, dxi_d, dyi_q, dyi_d;
  logic [FW-1:0]   k_q, k_d;
  logic [UW-1:0]   used_q, used_d;
  logic [CAW-1:0]  clr_q, clr_d;
  logic [RW-1:0]   own_q, own_d;
  logic [IdW-1:0]  id_q, id_d;
  logic [glpc_pkg::LimW-1:0] lim_q;

  logic                      done_d;
  logic [IdW-1:0]            cid_d;
  glpc_pkg::status_e         status_d;
  logic [COUNT_BITS-1:0]     cnt_d;
  logic signed [SumW-1:0]    sx_d, sy_d;

  logic [RW-1:0]   cell_mem [Cells];
  logic [RW-1:0]   cell_rdata_q;
  logic            cell_ren, cell_we;
  logic [CAW-1:0]  cell_raddr, cell_waddr;
  logic [RW-1:0]   cell_wdata;

  logic [CRW-1:0]  clu_mem [MAX_CLUSTERS];
  logic [CRW-1:0]  clu_rdata_q;
  logic            clu_ren, clu_we;
  logic [IdW-1:0]  clu_raddr, clu_waddr;
  logic [CRW-1:0]  clu_wdata;

  logic            near_start;
  glpc_pkg::near_res_t near_res;

  logic [GW:0]     gxw, gyw;
  logic [GW-1:0]   gx, gy;
  logic            nb_ok, nb_last;
  logic [1:0]      nxt_dx, nxt_dy;
  logic [FW-1:0]   row_fill, own_fill;
  logic [IdW-1:0]  slot_id;
  logic [COUNT_BITS-1:0] clu_n;
  logic signed [SumW-1:0] clu_sx, clu_sy;
  logic signed [LW-1:0]   in_x, in_y;
  logic signed [SW-1:0]   bx, by;
  logic [RW-1:0]   own_new;

  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  always_comb begin
    gxw      = {1'b0, cx_q} + (GW+1)'(dxi_q);
    gyw      = {1'b0, cy_q} + (GW+1)'(dyi_q);
    gx       = GW'(gxw - (GW+1)'(1));
    gy       = GW'(gyw - (GW+1)'(1));
    nb_ok    = (gxw != '0) && (gyw != '0) &&
               (gxw <= (GW+1)'(GRID_SIDE)) && (gyw <= (GW+1)'(GRID_SIDE));
    nb_last  = (dxi_q == 2'd2) && (dyi_q == 2'd2);
    nxt_dx   = (dyi_q == 2'd2) ? dxi_q + 2'd1 : dxi_q;
    nxt_dy   = (dyi_q == 2'd2) ? 2'd0 : dyi_q + 2'd1;
    row_fill = cell_rdata_q[RW-1 -: FW];
    own_fill = own_q[RW-1 -: FW];
    slot_id  = cell_rdata_q[k_q[KW-1:0]*IdW +: IdW];
    clu_n    = clu_rdata_q[CRW-1 -: COUNT_BITS];
    clu_sx   = clu_rdata_q[2*SumW-1 -: SumW];
    clu_sy   = clu_rdata_q[SumW-1:0];
    in_x     = LW'(point_x_i);
    in_y     = LW'(point_y_i);
    bx       = SW'(point_x_i) + Bias;
    by       = SW'(point_y_i) + Bias;
    own_new  = own_q;
    own_new[own_fill[KW-1:0]*IdW +: IdW] = used_q[IdW-1:0];
    own_new[RW-1 -: FW] = own_fill + FW'(1);
  end

  always_comb begin
    state_d  = state_q;
    x_d      = x_q;
    y_d      = y_q;
    cx_d     = cx_q;
    cy_d     = cy_q;
    dxi_d    = dxi_q;
    dyi_d    = dyi_q;
    k_d      = k_q;
    used_d   = used_q;
    clr_d    = clr_q;
    own_d    = own_q;
    id_d     = id_q;
    done_d   = 1'b0;
    cid_d    = '0;
    status_d = glpc_pkg::ST_JOIN;
    cnt_d    = '0;
    sx_d     = '0;
    sy_d     = '0;
    cell_ren   = 1'b0;
    cell_raddr = CAW'(gx) * CAW'(GRID_SIDE) + CAW'(gy);
    cell_we    = 1'b0;
    cell_waddr = CAW'(cx_q) * CAW'(GRID_SIDE) + CAW'(cy_q);
    cell_wdata = own_new;
    clu_ren    = 1'b0;
    clu_raddr  = slot_id;
    clu_we     = 1'b0;
    clu_waddr  = id_q;
    clu_wdata  = {clu_n + COUNT_BITS'(1), clu_sx + SumW'(x_q), clu_sy + SumW'(y_q)};
    near_start = 1'b0;

    unique case (state_q)
      S_CLEAR: begin
        cell_we    = 1'b1;
        cell_waddr = clr_q;
        cell_wdata = '0;
        clr_d      = clr_q + CAW'(1);
        if (clr_q == LastCell) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          if (in_x < -LimP || in_x > LimP || in_y < -LimP || in_y > LimP) begin
            done_d   = 1'b1;
            status_d = glpc_pkg::ST_OUTSIDE;
          end else begin
            x_d     = point_x_i;
            y_d     = point_y_i;
            cx_d    = bx[Shift +: GW];
            cy_d    = by[Shift +: GW];
            dxi_d   = 2'd0;
            dyi_d   = 2'd0;
            state_d = S_CELL;
          end
        end
      end
      S_CELL: begin
        if (nb_ok) begin
          cell_ren = 1'b1;
          state_d  = S_ROW;
        end else if (nb_last) begin
          state_d = S_DECIDE;
        end else begin
          dxi_d = nxt_dx;
          dyi_d = nxt_dy;
        end
      end
      S_ROW: begin
        // keep the own cell's row for the insert at the end
        if (dxi_q == 2'd1 && dyi_q == 2'd1) begin
          own_d = cell_rdata_q;
        end
        k_d     = '0;
        state_d = S_SLOT;
      end
      S_SLOT: begin
        if (k_q < row_fill && k_q < SlotsF) begin
          if (UW'(slot_id) < used_q) begin
            clu_ren = 1'b1;
            id_d    = slot_id;
            state_d = S_CLU;
          end else begin
            k_d = k_q + FW'(1);
          end
        end else if (nb_last) begin
          state_d = S_DECIDE;
        end else begin
          dxi_d   = nxt_dx;
          dyi_d   = nxt_dy;
          state_d = S_CELL;
        end
      end
      S_CLU: begin
        near_start = 1'b1;
        state_d    = S_TEST;
      end
      S_TEST: begin
        if (near_res.done) begin
          if (near_res.hit) begin
            done_d  = 1'b1;
            state_d = S_IDLE;
            if (clu_n == '1) begin
              status_d = glpc_pkg::ST_SATURATED;
            end else begin
              clu_we   = 1'b1;
              cid_d    = id_q;
              status_d = glpc_pkg::ST_JOIN;
              cnt_d    = clu_wdata[CRW-1 -: COUNT_BITS];
              sx_d     = clu_wdata[2*SumW-1 -: SumW];
              sy_d     = clu_wdata[SumW-1:0];
            end
          end else begin
            k_d     = k_q + FW'(1);
            state_d = S_SLOT;
          end
        end
      end
      S_DECIDE: begin
        done_d  = 1'b1;
        state_d = S_IDLE;
        if (used_q >= MaxU) begin
          status_d = glpc_pkg::ST_NO_FREE;
        end else if (own_fill >= SlotsF) begin
          status_d = glpc_pkg::ST_CELL_FULL;
        end else begin
          cell_we   = 1'b1;
          clu_we    = 1'b1;
          clu_waddr = used_q[IdW-1:0];
          clu_wdata = {COUNT_BITS'(1), SumW'(x_q), SumW'(y_q)};
          used_d    = used_q + UW'(1);
          cid_d     = used_q[IdW-1:0];
          status_d  = glpc_pkg::ST_NEW;
          cnt_d     = COUNT_BITS'(1);
          sx_d      = SumW'(x_q);
          sy_d      = SumW'(y_q);
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_CLEAR;
      used_q         <= '0;
      clr_q          <= '0;
      lim_q          <= glpc_pkg::LimReset;
      done_o         <= 1'b0;
      dxi_q          <= '0;
      dyi_q          <= '0;
      k_q            <= '0;
    end else begin
      state_q        <= state_d;
      used_q         <= used_d;
      clr_q          <= clr_d;
      dxi_q          <= dxi_d;
      dyi_q          <= dyi_d;
      k_q            <= k_d;
      done_o         <= done_d;
      if (cfg_valid_i) begin
        lim_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q            <= x_d;
    y_q            <= y_d;
    cx_q           <= cx_d;
    cy_q           <= cy_d;
    own_q          <= own_d;
    id_q           <= id_d;
    cluster_id_o   <= cid_d;
    status_o       <= status_d;
    member_count_o <= cnt_d;
    sum_x_o        <= sx_d;
    sum_y_o        <= sy_d;
  end

  always_ff @(posedge clk_i) begin
    if (cell_we) begin
      cell_mem[cell_waddr] <= cell_wdata;
    end
    if (cell_ren) begin
      cell_rdata_q <= cell_mem[cell_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (clu_we) begin
      clu_mem[clu_waddr] <= clu_wdata;
    end
    if (clu_ren) begin
      clu_rdata_q <= clu_mem[clu_raddr];
    end
  end

  glpc_near #(
    .COUNT_BITS(COUNT_BITS)
  ) u_near (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(near_start),
    .x_i    (x_q),
    .y_i    (y_q),
    .n_i    (clu_n),
    .sx_i   (clu_sx),
    .sy_i   (clu_sy),
    .lim_i  (lim_q),
    .res_o  (near_res)
  );

  a_test_only_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    near_res.done |-> state_q == S_TEST)
    else $error("distance result outside test wait");

  a_used_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= MaxU)
    else $error("cluster count beyond capacity");

  a_new_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o == glpc_pkg::ST_NEW |-> member_count_o == COUNT_BITS'(1))
    else $error("new cluster with member count not one");

  a_request_answered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy || done_o)
    else $error("request neither worked on nor answered");

  a_used_grows_on_new: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o == glpc_pkg::ST_NEW |-> used_q == $past(used_q) + UW'(1))
    else $error("new cluster without count advance");

endmodule
